// ===== design/mipsdec_pkg.sv =====
package mipsdec_pkg;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_I_FIRST = 6'h04;
   localparam logic [5:0] OP_I_LAST  = 6'h2E;
   localparam logic [5:0] OP_COP0    = 6'h10;
   localparam logic [5:0] OP_COP2    = 6'h12;
   localparam logic [5:0] OP_LWC1    = 6'h31;
   localparam logic [5:0] OP_SWC1    = 6'h39;
   localparam logic [5:0] OP_LWC2    = 6'h32;
   localparam logic [5:0] OP_SWC2    = 6'h3A;

   // special function codes handled outside the r table
   localparam logic [5:0] FN_SYSCALL = 6'h0C;
   localparam logic [5:0] FN_BREAK   = 6'h0D;
   localparam logic [5:0] FN_TGE     = 6'h30;
   localparam logic [5:0] FN_TEQ     = 6'h34;

   // coprocessor move selectors in rs
   localparam logic [4:0] RS_MF = 5'd0;
   localparam logic [4:0] RS_CF = 5'd2;
   localparam logic [4:0] RS_MT = 5'd4;
   localparam logic [4:0] RS_CT = 5'd6;

   localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;

   typedef enum logic [2:0] {
      FMT_R, FMT_TRAP, FMT_I, FMT_J, FMT_SYS, FMT_COP0, FMT_COP2, FMT_COPLS
   } format_type;

   typedef enum logic [2:0] {
      CAT_NONE, CAT_JUMP, CAT_CALL, CAT_COND, CAT_LOAD, CAT_STORE
   } category_type;

   typedef enum logic [2:0] {
      FORM_NONE, FORM_REG, FORM_RRR, FORM_DISPL, FORM_RI, FORM_RRI, FORM_RRA
   } form_type;

   typedef enum logic [6:0] {
      MN_NONE = 7'd0,
      MN_ADD, MN_ADDU, MN_AND, MN_DIV, MN_DIVU, MN_MULT, MN_MULTU, MN_NOR, MN_OR,
      MN_SLL, MN_SRA, MN_SRL, MN_SUB, MN_SUBU, MN_XOR, MN_SLT, MN_SLTU, MN_JR,
      MN_MFHI, MN_MFLO, MN_MTHI, MN_MTLO, MN_SLLV, MN_SRAV, MN_SRLV, MN_JALR,
      MN_TGE, MN_TEQ,
      MN_ADDI, MN_ADDIU, MN_ANDI, MN_ORI, MN_LUI, MN_BEQ, MN_BNE, MN_BGEZ,
      MN_BGTZ, MN_BLEZ, MN_LB, MN_LBU, MN_LH, MN_LHU, MN_LW, MN_LWL, MN_LWR,
      MN_SB, MN_SH, MN_SW, MN_SWL, MN_SWR, MN_LHI, MN_LLO, MN_SLTI, MN_SLTIU,
      MN_XORI,
      MN_J, MN_JAL,
      MN_SYSCALL, MN_BREAK,
      MN_MFC0, MN_MTC0,
      MN_MFC2, MN_MTC2, MN_CFC2, MN_CTC2,
      MN_LWC1, MN_SWC1, MN_LWC2, MN_SWC2
   } mnemonic_type;

   typedef struct packed {
      logic          valid_res;
      format_type    format_code;
      mnemonic_type  mnemonic_code;
      category_type  category_code;
      form_type      operand_form;
      logic [4:0]    first_register;
      logic [4:0]    second_register;
      logic [4:0]    third_register;
      logic [15:0]   immediate_value;
      logic [31:0]   target_address;
      logic          has_delay_slot;
      logic          stops_flow;
   } decode_result_type;

   // r format table, indexed by funct
   function automatic mnemonic_type r_lookup(input logic [5:0] fn);
      mnemonic_type m;
      unique case (fn)
         6'h20:   m = MN_ADD;
         6'h21:   m = MN_ADDU;
         6'h24:   m = MN_AND;
         6'h1A:   m = MN_DIV;
         6'h1B:   m = MN_DIVU;
         6'h18:   m = MN_MULT;
         6'h19:   m = MN_MULTU;
         6'h27:   m = MN_NOR;
         6'h25:   m = MN_OR;
         6'h00:   m = MN_SLL;
         6'h03:   m = MN_SRA;
         6'h02:   m = MN_SRL;
         6'h22:   m = MN_SUB;
         6'h23:   m = MN_SUBU;
         6'h26:   m = MN_XOR;
         6'h2A:   m = MN_SLT;
         6'h2B:   m = MN_SLTU;
         6'h08:   m = MN_JR;
         6'h10:   m = MN_MFHI;
         6'h12:   m = MN_MFLO;
         6'h11:   m = MN_MTHI;
         6'h13:   m = MN_MTLO;
         6'h04:   m = MN_SLLV;
         6'h07:   m = MN_SRAV;
         6'h06:   m = MN_SRLV;
         6'h09:   m = MN_JALR;
         default: m = MN_NONE;
      endcase
      return m;
   endfunction

   // i format table, indexed by opcode
   function automatic mnemonic_type i_lookup(input logic [5:0] op);
      mnemonic_type m;
      unique case (op)
         6'h08:   m = MN_ADDI;
         6'h09:   m = MN_ADDIU;
         6'h0C:   m = MN_ANDI;
         6'h0D:   m = MN_ORI;
         6'h0F:   m = MN_LUI;
         6'h04:   m = MN_BEQ;
         6'h05:   m = MN_BNE;
         6'h01:   m = MN_BGEZ;
         6'h07:   m = MN_BGTZ;
         6'h06:   m = MN_BLEZ;
         6'h20:   m = MN_LB;
         6'h24:   m = MN_LBU;
         6'h21:   m = MN_LH;
         6'h25:   m = MN_LHU;
         6'h23:   m = MN_LW;
         6'h22:   m = MN_LWL;
         6'h26:   m = MN_LWR;
         6'h28:   m = MN_SB;
         6'h29:   m = MN_SH;
         6'h2B:   m = MN_SW;
         6'h2A:   m = MN_SWL;
         6'h2E:   m = MN_SWR;
         6'h19:   m = MN_LHI;
         6'h18:   m = MN_LLO;
         6'h0A:   m = MN_SLTI;
         6'h0B:   m = MN_SLTIU;
         6'h0E:   m = MN_XORI;
         default: m = MN_NONE;
      endcase
      return m;
   endfunction

   function automatic category_type cat_lookup(input mnemonic_type m);
      category_type c;
      unique case (m)
         MN_JR, MN_J:                                 c = CAT_JUMP;
         MN_JALR, MN_JAL:                             c = CAT_CALL;
         MN_BEQ, MN_BNE, MN_BGEZ, MN_BGTZ, MN_BLEZ:   c = CAT_COND;
         MN_LUI, MN_LB, MN_LBU, MN_LH, MN_LHU, MN_LW,
         MN_LWL, MN_LWR, MN_MFC0, MN_MTC0:            c = CAT_LOAD;
         MN_SB, MN_SH, MN_SW, MN_SWL, MN_SWR:         c = CAT_STORE;
         default:                                     c = CAT_NONE;
      endcase
      return c;
   endfunction

endpackage

// ===== design/mipsdec_decode.sv =====
module mipsdec_decode import mipsdec_pkg::*; (
   input  logic [31:0]       instruction_word,
   input  logic [31:0]       instruction_address,
   output decode_result_type result
);

   logic [5:0]   op;
   logic [4:0]   rs;
   logic [4:0]   rt;
   logic [4:0]   rd;
   logic [5:0]   fn;
   logic [15:0]  imm;
   logic [31:0]  pc_plus4;
   logic [31:0]  branch_target;
   logic [31:0]  jump_target;

   assign op  = instruction_word[31:26];
   assign rs  = instruction_word[25:21];
   assign rt  = instruction_word[20:16];
   assign rd  = instruction_word[15:11];
   assign fn  = instruction_word[5:0];
   assign imm = instruction_word[15:0];

   assign pc_plus4      = instruction_address + 32'd4;
   assign branch_target = pc_plus4 + {{14{imm[15]}}, imm, 2'b00};
   assign jump_target   = (pc_plus4 & JUMP_REGION_MASK) | {4'd0, instruction_word[25:0], 2'b00};

   always_comb begin
      format_type   fmt;
      mnemonic_type m;
      logic         known;

      fmt   = FMT_R;
      m     = MN_NONE;
      known = 1'b1;

      // format sort; coprocessor opcodes take priority over the i range
      priority if (op == OP_SPECIAL) begin
         if (fn == FN_SYSCALL || fn == FN_BREAK) begin
            fmt = FMT_SYS;
            m   = (fn == FN_SYSCALL) ? MN_SYSCALL : MN_BREAK;
         end else if (fn == FN_TGE || fn == FN_TEQ) begin
            fmt = FMT_TRAP;
            m   = (fn == FN_TGE) ? MN_TGE : MN_TEQ;
         end else begin
            fmt = FMT_R;
            m   = r_lookup(fn);
         end
      end else if (op == OP_COP0) begin
         fmt = FMT_COP0;
         m   = (rs == RS_MF) ? MN_MFC0 : (rs == RS_MT) ? MN_MTC0 : MN_NONE;
      end else if (op == OP_COP2) begin
         fmt = FMT_COP2;
         m   = (rs == RS_MF) ? MN_MFC2 : (rs == RS_MT) ? MN_MTC2 :
               (rs == RS_CF) ? MN_CFC2 : (rs == RS_CT) ? MN_CTC2 : MN_NONE;
      end else if (op == OP_LWC1 || op == OP_SWC1 || op == OP_LWC2 || op == OP_SWC2) begin
         fmt = FMT_COPLS;
         m   = (op == OP_LWC1) ? MN_LWC1 : (op == OP_SWC1) ? MN_SWC1 :
               (op == OP_LWC2) ? MN_LWC2 : MN_SWC2;
      end else if ((op >= OP_I_FIRST && op <= OP_I_LAST) || op == OP_REGIMM) begin
         fmt = FMT_I;
         m   = i_lookup(op);
      end else if (op == OP_J || op == OP_JAL) begin
         fmt = FMT_J;
         m   = (op == OP_J) ? MN_J : MN_JAL;
      end else begin
         known = 1'b0;
      end

      result               = '0;
      result.valid_res     = known;
      result.format_code   = fmt;
      result.mnemonic_code = m;

      if (m != MN_NONE) begin
         result.category_code  = cat_lookup(m);
         result.has_delay_slot = (m == MN_BEQ) || (m == MN_BNE) || (m == MN_BGEZ) ||
                                 (m == MN_BGTZ) || (m == MN_BLEZ) || (m == MN_J) ||
                                 (m == MN_JAL) || (m == MN_JR) || (m == MN_JALR);
         result.stops_flow     = (m == MN_BREAK);

         if (fmt == FMT_R) begin
            if (m == MN_JR || m == MN_JALR) begin
               result.operand_form   = FORM_REG;
               result.first_register = rs;
            end else begin
               result.operand_form    = FORM_RRR;
               result.first_register  = rd;
               result.second_register = rs;
               result.third_register  = rt;
            end
         end else if (fmt == FMT_I) begin
            result.first_register = rt;
            if (m >= MN_LB && m <= MN_SWR) begin
               result.operand_form    = FORM_DISPL;
               result.second_register = rs;
               result.immediate_value = imm;
            end else if (m == MN_LUI) begin
               result.operand_form    = FORM_RI;
               result.immediate_value = imm;
            end else if (cat_lookup(m) == CAT_COND) begin
               result.operand_form    = FORM_RRA;
               result.second_register = rs;
               result.target_address  = branch_target;
            end else begin
               result.operand_form    = FORM_RRI;
               result.second_register = rs;
               result.immediate_value = imm;
            end
         end else if (fmt == FMT_J) begin
            result.target_address = jump_target;
         end
      end

      // unknown format gives an all-zero result
      if (!known) begin
         result = '0;
      end
   end

endmodule

// ===== design/mips32_instruction_decoder.sv =====
// mips32 instruction decoder: takes one instruction word with its address per
// cycle while not stalled and returns one decoded word per input, in order. a
// word passes the input register, then the result register after the decode
// tables and the two target adders; sustained rate is one word per cycle while
// rsp_tready stays high, set by the single decode pass between those registers.
// while a result waits on rsp_tready the input register still takes one more
// word; after that req_tready stays low until the result register drains.
module mips32_instruction_decoder import mipsdec_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] instruction_word, [63:32] instruction_address

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] valid_res, [3:1] format_code, [10:4] mnemonic_code,
   // [13:11] category_code, [16:14] operand_form, [21:17] first_register,
   // [26:22] second_register, [31:27] third_register, [47:32] immediate_value,
   // [79:48] target_address, [80] has_delay_slot, [81] stops_flow, [87:82] zero
   output logic [87:0] rsp_tdata
);

   // input stage
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [31:0]       word_ff;
   logic [31:0]       addr_ff;

   // result stage
   logic              s2_valid_ff;
   logic              s2_valid_in;
   decode_result_type res_ff;
   decode_result_type res_in;

   logic              req_accept;
   logic              s2_load;

   // input stage advances whenever the result register is empty or draining
   assign s2_load    = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || !s2_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (rsp_tready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         word_ff <= req_tdata[31:0];
         addr_ff <= req_tdata[63:32];
      end
      if (s2_load) begin
         res_ff <= res_in;
      end
   end

   // format sort, table lookup, operand pick and target adders
   mipsdec_decode u_decode (
      .instruction_word    (word_ff),
      .instruction_address (addr_ff),
      .result              (res_in)
   );

   assign rsp_tvalid = s2_valid_ff;

   always_comb begin
      rsp_tdata        = '0;
      rsp_tdata[0]     = res_ff.valid_res;
      rsp_tdata[3:1]   = res_ff.format_code;
      rsp_tdata[10:4]  = res_ff.mnemonic_code;
      rsp_tdata[13:11] = res_ff.category_code;
      rsp_tdata[16:14] = res_ff.operand_form;
      rsp_tdata[21:17] = res_ff.first_register;
      rsp_tdata[26:22] = res_ff.second_register;
      rsp_tdata[31:27] = res_ff.third_register;
      rsp_tdata[47:32] = res_ff.immediate_value;
      rsp_tdata[79:48] = res_ff.target_address;
      rsp_tdata[80]    = res_ff.has_delay_slot;
      rsp_tdata[81]    = res_ff.stops_flow;
   end

endmodule
